@@ design/sws_pkg.sv @@
// Shared constants, codes and types for the sliding window statistics block.
`default_nettype none

package sws_pkg;

   // Window storage depth and the field widths it implies.
   localparam int MAX_DEPTH = 64;
   localparam int ADDR_W    = $clog2(MAX_DEPTH);
   localparam int CAP_W     = 7;
   localparam int OP_W      = 2;
   localparam int POS_W     = 6;
   localparam int TS_W      = 48;
   localparam int KB_W      = 32;
   localparam int SUM_W     = 38;
   localparam int ENTRY_W   = TS_W + KB_W;

   // Step counter width of the mean divider.
   localparam int DIV_CNT_W = $clog2(SUM_W + 1);

   // Capacity limits; reset value is the full depth.
   localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_DEPTH);
   localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(1);
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_DEPTH);

   // Request operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_STATS = 2'd1,
      OP_GET   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // One response word.
   typedef struct packed {
      logic             ok;
      logic [CAP_W-1:0] fill_count;
      logic [SUM_W-1:0] sum_kb;
      logic [KB_W-1:0]  min_kb;
      logic [KB_W-1:0]  max_kb;
      logic [KB_W-1:0]  mean_kb;
      logic [TS_W-1:0]  oldest_ts;
      logic [TS_W-1:0]  newest_ts;
      logic [TS_W-1:0]  sample_ts;
      logic [KB_W-1:0]  sample_kb;
   } rsp_type;

endpackage

`default_nettype wire

@@ design/sliding_window_stats.sv @@
// Top level of the sliding window statistics block: control, window RAM and divider.
//
// Usage: requests arrive on the req_ channel (valid/stall); one response word
// leaves on the rsp_ channel per request. A push stores a timestamped sample
// at the ring head, a stats request walks the held samples oldest to newest,
// a get returns the nth oldest sample and a clear empties the window.
// csr_wr_en writes the window capacity (0 reads as 1, above 64 as 64) and
// empties the window; write it only while the block is idle.
// A stats request issues one window RAM read per held sample, then runs the
// bit-serial divider that forms the mean; on an empty window it does neither.
// One request is in work at a time; req_stall is high from acceptance until
// the response is loaded into the output register. The output register lets
// the next request be accepted while a response still waits; if rsp_stall
// holds, a finished response waits inside and the block stops accepting.
// Reset empties the window and sets capacity to 64; sample contents are not
// cleared and are only read once written.
`default_nettype none

module sliding_window_stats (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [sws_pkg::OP_W-1:0]     req_op,
   input  wire logic [sws_pkg::TS_W-1:0]     req_new_ts,
   input  wire logic [sws_pkg::KB_W-1:0]     req_new_kb,
   input  wire logic [sws_pkg::POS_W-1:0]    req_position,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_ok,
   output logic      [sws_pkg::CAP_W-1:0]    rsp_fill_count,
   output logic      [sws_pkg::SUM_W-1:0]    rsp_sum_kb,
   output logic      [sws_pkg::KB_W-1:0]     rsp_min_kb,
   output logic      [sws_pkg::KB_W-1:0]     rsp_max_kb,
   output logic      [sws_pkg::KB_W-1:0]     rsp_mean_kb,
   output logic      [sws_pkg::TS_W-1:0]     rsp_oldest_ts,
   output logic      [sws_pkg::TS_W-1:0]     rsp_newest_ts,
   output logic      [sws_pkg::TS_W-1:0]     rsp_sample_ts,
   output logic      [sws_pkg::KB_W-1:0]     rsp_sample_kb,
   input  wire logic                         csr_wr_en,
   input  wire logic [sws_pkg::CAP_W-1:0]    csr_wr_data
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_WALK = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_GET  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type                        state_ff, state_in;
   logic [sws_pkg::ADDR_W-1:0]       wp_ff, wp_in;
   logic [sws_pkg::CAP_W-1:0]        fill_ff, fill_in;
   logic [sws_pkg::CAP_W-1:0]        cap_ff, cap_in;
   logic [sws_pkg::ADDR_W-1:0]       rd_slot_ff, rd_slot_in;
   logic [sws_pkg::CAP_W-1:0]        rd_cnt_ff, rd_cnt_in;
   logic [sws_pkg::CAP_W-1:0]        acc_cnt_ff, acc_cnt_in;
   logic                             dv_ff, dv_in;
   sws_pkg::rsp_type                 res_ff, res_in;
   sws_pkg::rsp_type                 rsp_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_load;

   logic                             ram_we;
   logic [sws_pkg::ADDR_W-1:0]       ram_raddr;
   logic [sws_pkg::ENTRY_W-1:0]      ram_wdata;
   logic [sws_pkg::ENTRY_W-1:0]      ram_rdata;
   logic [sws_pkg::TS_W-1:0]         rd_ts;
   logic [sws_pkg::KB_W-1:0]         rd_kb;

   logic                             div_start;
   logic                             div_done;
   logic [sws_pkg::SUM_W-1:0]        div_quo;
   logic [sws_pkg::SUM_W-1:0]        sum_nxt;

   logic [sws_pkg::CAP_W-1:0]        wp_ext;
   logic [sws_pkg::CAP_W-1:0]        wp_inc;
   logic [sws_pkg::CAP_W-1:0]        base;
   logic [sws_pkg::CAP_W:0]          get_raw;
   logic [sws_pkg::CAP_W:0]          get_slot;
   logic [sws_pkg::CAP_W-1:0]        slot_inc;
   logic [sws_pkg::CAP_W-1:0]        cap_wr;

   // Oldest slot, requested slot and the ring increments.
   always_comb begin
      wp_ext = sws_pkg::CAP_W'(wp_ff);
      wp_inc = wp_ext + sws_pkg::CAP_W'(1);
      if (wp_ext >= fill_ff) begin
         base = wp_ext - fill_ff;
      end else begin
         base = wp_ext + cap_ff - fill_ff;
      end
      get_raw = {1'b0, base} + (sws_pkg::CAP_W + 1)'(req_position);
      if (get_raw >= {1'b0, cap_ff}) begin
         get_slot = get_raw - {1'b0, cap_ff};
      end else begin
         get_slot = get_raw;
      end
      slot_inc = sws_pkg::CAP_W'(rd_slot_ff) + sws_pkg::CAP_W'(1);
   end

   // Capacity written through the register port, clamped to the legal range.
   always_comb begin
      if (csr_wr_data == '0) begin
         cap_wr = sws_pkg::CAP_MIN;
      end else if (csr_wr_data > sws_pkg::CAP_MAX) begin
         cap_wr = sws_pkg::CAP_MAX;
      end else begin
         cap_wr = csr_wr_data;
      end
   end

   assign rd_ts     = ram_rdata[sws_pkg::ENTRY_W-1:sws_pkg::KB_W];
   assign rd_kb     = ram_rdata[sws_pkg::KB_W-1:0];
   assign sum_nxt   = res_ff.sum_kb + sws_pkg::SUM_W'(rd_kb);
   assign ram_wdata = {req_new_ts, req_new_kb};
   assign ram_raddr = (state_ff == ST_IDLE) ? get_slot[sws_pkg::ADDR_W-1:0] : rd_slot_ff;

   // Main sequencer.
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      cap_in       = cap_ff;
      rd_slot_in   = rd_slot_ff;
      rd_cnt_in    = rd_cnt_ff;
      acc_cnt_in   = acc_cnt_ff;
      dv_in        = 1'b0;
      res_in       = res_ff;
      ram_we       = 1'b0;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in            = '0;
               res_in.fill_count = fill_ff;
               state_in          = ST_DONE;
               unique case (sws_pkg::op_type'(req_op))
                  sws_pkg::OP_PUSH: begin
                     ram_we = 1'b1;
                     if (wp_inc == cap_ff) begin
                        wp_in = '0;
                     end else begin
                        wp_in = wp_inc[sws_pkg::ADDR_W-1:0];
                     end
                     if (fill_ff < cap_ff) begin
                        fill_in = fill_ff + sws_pkg::CAP_W'(1);
                     end
                     res_in.ok         = 1'b1;
                     res_in.fill_count = fill_in;
                  end
                  sws_pkg::OP_STATS: begin
                     if (fill_ff != '0) begin
                        res_in.ok     = 1'b1;
                        res_in.min_kb = '1;
                        rd_slot_in    = base[sws_pkg::ADDR_W-1:0];
                        rd_cnt_in     = '0;
                        acc_cnt_in    = '0;
                        state_in      = ST_WALK;
                     end
                  end
                  sws_pkg::OP_GET: begin
                     if (sws_pkg::CAP_W'(req_position) < fill_ff) begin
                        res_in.ok = 1'b1;
                        state_in  = ST_GET;
                     end
                  end
                  sws_pkg::OP_CLEAR: begin
                     wp_in             = '0;
                     fill_in           = '0;
                     res_in.ok         = 1'b1;
                     res_in.fill_count = '0;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // Issue one read per cycle while samples remain.
            if (rd_cnt_ff < fill_ff) begin
               dv_in     = 1'b1;
               rd_cnt_in = rd_cnt_ff + sws_pkg::CAP_W'(1);
               if (slot_inc == cap_ff) begin
                  rd_slot_in = '0;
               end else begin
                  rd_slot_in = slot_inc[sws_pkg::ADDR_W-1:0];
               end
            end
            // Fold in the word read on the previous cycle.
            if (dv_ff) begin
               res_in.sum_kb = sum_nxt;
               if (rd_kb < res_ff.min_kb) begin
                  res_in.min_kb = rd_kb;
               end
               if (rd_kb > res_ff.max_kb) begin
                  res_in.max_kb = rd_kb;
               end
               if (acc_cnt_ff == '0) begin
                  res_in.oldest_ts = rd_ts;
               end
               res_in.newest_ts = rd_ts;
               acc_cnt_in       = acc_cnt_ff + sws_pkg::CAP_W'(1);
               if (acc_cnt_in == fill_ff) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in.mean_kb = div_quo[sws_pkg::KB_W-1:0];
               state_in       = ST_DONE;
            end
         end
         ST_GET: begin
            res_in.sample_ts = rd_ts;
            res_in.sample_kb = rd_kb;
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A capacity write empties the window.
      if (csr_wr_en) begin
         cap_in  = cap_wr;
         wp_in   = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         cap_ff       <= sws_pkg::CAP_RESET;
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
         dv_ff        <= dv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_slot_ff <= rd_slot_in;
      rd_cnt_ff  <= rd_cnt_in;
      acc_cnt_ff <= acc_cnt_in;
      res_ff     <= res_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   // Sample storage: timestamp and value side by side.
   sws_ram #(
      .WIDTH (sws_pkg::ENTRY_W),
      .DEPTH (sws_pkg::MAX_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Mean of the window.
   sws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_nxt),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ff.ok;
   assign rsp_fill_count = rsp_ff.fill_count;
   assign rsp_sum_kb     = rsp_ff.sum_kb;
   assign rsp_min_kb     = rsp_ff.min_kb;
   assign rsp_max_kb     = rsp_ff.max_kb;
   assign rsp_mean_kb    = rsp_ff.mean_kb;
   assign rsp_oldest_ts  = rsp_ff.oldest_ts;
   assign rsp_newest_ts  = rsp_ff.newest_ts;
   assign rsp_sample_ts  = rsp_ff.sample_ts;
   assign rsp_sample_kb  = rsp_ff.sample_kb;

endmodule

`default_nettype wire

@@ design/sws_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module sws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/sws_div.sv @@
// Restoring divider, one quotient bit per cycle, for the window mean.
`default_nettype none

module sws_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [sws_pkg::SUM_W-1:0]     dividend,
   input  wire logic [sws_pkg::CAP_W-1:0]     divisor,
   output logic                               done,
   output logic      [sws_pkg::SUM_W-1:0]     quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [sws_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [sws_pkg::SUM_W-1:0]     quo_ff, quo_in;
   logic [sws_pkg::CAP_W-1:0]     rem_ff, rem_in;
   logic [sws_pkg::CAP_W-1:0]     dvs_ff, dvs_in;
   logic [sws_pkg::CAP_W:0]       trial;

   // One shift-and-subtract step per cycle while busy.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[sws_pkg::SUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = sws_pkg::CAP_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[sws_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[sws_pkg::CAP_W-1:0];
            quo_in = {quo_ff[sws_pkg::SUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + sws_pkg::DIV_CNT_W'(1);
         if (cnt_ff == sws_pkg::DIV_CNT_W'(sws_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
